// ===== hdl/tbom_pkg.sv =====
package tbom_pkg;

    localparam logic [1:0] NONE_IDX = 2'd3;

    typedef enum logic [1:0] {
        CMD_COMMIT  = 2'd0,
        CMD_PUBLISH = 2'd1,
        CMD_MARK    = 2'd2,
        CMD_TAKE    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] session_id;
        logic [31:0] current_frame;
        logic [31:0] finished_frame;
        logic [31:0] finished_session;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  src_index;
        logic [1:0]  dst_index;
        logic [1:0]  read_index;
        logic        waited;
        logic [31:0] waited_frame;
        logic        no_free_error;
    } out_item_t;

    // controller to datapath operations
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_RELEASE = 3'd2,
        OP_COMMIT  = 3'd3,
        OP_PUBLISH = 3'd4,
        OP_MARK    = 3'd5,
        OP_TAKE    = 3'd6
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pub_more;
    } dp_status_t;

    // wrap-aware "x is done relative to fin"
    function automatic logic is_done(input logic [31:0] x, input logic [31:0] fin);
        logic [31:0] d;
        begin
            d = fin - x;
            return ~d[31];
        end
    endfunction

endpackage

// ===== hdl/tbom_ctrl.sv =====
module tbom_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            in_cmd,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  tbom_pkg::dp_status_t  status,
    output tbom_pkg::dp_cmd_t     dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RELEASE,
        S_EXEC,
        S_PUBLISH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [1:0] cmd_reg, cmd_next;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;

    // command issue
    always_comb
    begin
        dp_cmd.op = tbom_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    dp_cmd.op = tbom_pkg::OP_LOAD;
                end
            end
            S_RELEASE: dp_cmd.op = tbom_pkg::OP_RELEASE;
            S_EXEC:
            begin
                unique case (tbom_pkg::cmd_t'(cmd_reg))
                    tbom_pkg::CMD_COMMIT:  dp_cmd.op = tbom_pkg::OP_COMMIT;
                    tbom_pkg::CMD_PUBLISH: dp_cmd.op = tbom_pkg::OP_NONE;
                    tbom_pkg::CMD_MARK:    dp_cmd.op = tbom_pkg::OP_MARK;
                    tbom_pkg::CMD_TAKE:    dp_cmd.op = tbom_pkg::OP_TAKE;
                    default:               dp_cmd.op = tbom_pkg::OP_NONE;
                endcase
            end
            S_PUBLISH: dp_cmd.op = tbom_pkg::OP_PUBLISH;
            S_DONE:    dp_cmd.op = tbom_pkg::OP_NONE;
            default:   dp_cmd.op = tbom_pkg::OP_NONE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd_next = in_cmd;
                    if (tbom_pkg::cmd_t'(in_cmd) == tbom_pkg::CMD_COMMIT ||
                        tbom_pkg::cmd_t'(in_cmd) == tbom_pkg::CMD_TAKE)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_RELEASE;
                    end
                end
            end
            S_RELEASE:
            begin
                if (tbom_pkg::cmd_t'(cmd_reg) == tbom_pkg::CMD_PUBLISH)
                begin
                    state_next = S_PUBLISH;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:    state_next = S_DONE;
            S_PUBLISH:
            begin
                if (!status.pub_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
        end
    end

    // accept only when nothing is held or in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("accept while busy");

    a_done_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid_reg)
        else $error("result not presented after done");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule

// ===== hdl/tbom_dp.sv =====
module tbom_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbom_pkg::in_item_t   in_data,
    input  tbom_pkg::dp_cmd_t    dp_cmd,
    output tbom_pkg::dp_status_t status,
    output tbom_pkg::out_item_t  out_data
);

    localparam logic [1:0] NONE = tbom_pkg::NONE_IDX;

    logic [1:0]  src_reg, dst_reg, rd_reg, spr_reg;
    logic [31:0] tag_frame_reg [3];
    logic [2:0]  tag_valid_reg;
    logic [31:0] pend_sess_reg [3];
    logic [1:0]  pend_buf_reg  [3];
    logic [1:0]  pend_cnt_reg;
    tbom_pkg::in_item_t item_reg;
    logic        waited_reg, err_reg;
    logic [31:0] wframe_reg;

    // working copies
    logic [1:0]  src, dst, rd, spr;
    logic [31:0] tf [3];
    logic [2:0]  tv;
    logic [31:0] ps [3];
    logic [1:0]  pb [3];
    logic [1:0]  pc;
    logic        w, e;
    logic [31:0] wf;
    logic        pub_go;

    function automatic logic free_ok(input logic [1:0] i, input logic [1:0] s,
                                     input logic [1:0] d, input logic [1:0] r,
                                     input logic [2:0] v);
        return (i != 2'd3) && (i != s) && (i != d) && (i != r) && !v[i];
    endfunction

    // one step of the current operation
    always_comb
    begin
        logic [1:0] old;
        logic       hit;
        logic [1:0] hpos;
        src = src_reg; dst = dst_reg; rd = rd_reg; spr = spr_reg;
        tv = tag_valid_reg; pc = pend_cnt_reg;
        w = waited_reg; e = err_reg; wf = wframe_reg;
        hit = 1'b0; hpos = 2'd0; old = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            tf[k] = tag_frame_reg[k];
            ps[k] = pend_sess_reg[k];
            pb[k] = pend_buf_reg[k];
        end
        pub_go = (pend_cnt_reg != 2'd0) &&
                 tbom_pkg::is_done(pend_sess_reg[0], item_reg.finished_session);
        unique case (dp_cmd.op)
            tbom_pkg::OP_NONE: ;
            tbom_pkg::OP_LOAD:
            begin
                w = 1'b0; e = 1'b0; wf = '0;
            end
            tbom_pkg::OP_RELEASE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (tv[k] && tbom_pkg::is_done(tf[k], item_reg.finished_frame))
                    begin
                        tv[k] = 1'b0;
                        if (spr == NONE && free_ok(2'(k), src, dst, rd, tv))
                        begin
                            spr = 2'(k);
                        end
                    end
                end
            end
            tbom_pkg::OP_COMMIT, tbom_pkg::OP_TAKE:
            begin
                if (dst != NONE && dp_cmd.op == tbom_pkg::OP_COMMIT)
                begin
                    // drop first pending write targeting dst
                    for (int k = 0; k < 3; k++)
                    begin
                        if (!hit && 2'(k) < pc && pb[k] == dst)
                        begin
                            hit = 1'b1; hpos = 2'(k);
                        end
                    end
                    if (hit)
                    begin
                        if (hpos == 2'd0)
                        begin
                            ps[0] = ps[1]; pb[0] = pb[1];
                        end
                        if (hpos <= 2'd1)
                        begin
                            ps[1] = ps[2]; pb[1] = pb[2];
                        end
                        pc = pc - 2'd1;
                    end
                    old = src;
                    src = dst;
                end
                if ((dp_cmd.op == tbom_pkg::OP_COMMIT && dst_reg != NONE && old == rd
                     && spr == NONE) ||
                    (dp_cmd.op == tbom_pkg::OP_TAKE && dst == NONE))
                begin
                    // wait_spare: release done frames, then force
                    for (int k = 0; k < 3; k++)
                    begin
                        if (tv[k] && tbom_pkg::is_done(tf[k], item_reg.finished_frame))
                        begin
                            tv[k] = 1'b0;
                            if (spr == NONE && free_ok(2'(k), src, dst, rd, tv))
                            begin
                                spr = 2'(k);
                            end
                        end
                    end
                    if (spr == NONE)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (spr == NONE && 2'(k) != src && 2'(k) != dst
                                && 2'(k) != rd)
                            begin
                                if (tv[k])
                                begin
                                    w = 1'b1; wf = tf[k]; tv[k] = 1'b0;
                                end
                                spr = 2'(k);
                            end
                        end
                        if (spr == NONE)
                        begin
                            e = 1'b1;
                        end
                    end
                end
                if (dp_cmd.op == tbom_pkg::OP_COMMIT && dst_reg != NONE)
                begin
                    dst = (old == rd) ? spr : old;
                    spr = NONE;
                    if (pc != 2'd0 && ps[pc - 2'd1] == item_reg.session_id)
                    begin
                        pb[pc - 2'd1] = src;
                    end
                    else
                    begin
                        if (pc == 2'd3)
                        begin
                            ps[0] = ps[1]; pb[0] = pb[1];
                            ps[1] = ps[2]; pb[1] = pb[2];
                            pc = 2'd2;
                        end
                        ps[pc] = item_reg.session_id;
                        pb[pc] = src;
                        pc = pc + 2'd1;
                    end
                end
                else if (dp_cmd.op == tbom_pkg::OP_TAKE && dst_reg == NONE)
                begin
                    dst = spr;
                    spr = NONE;
                end
            end
            tbom_pkg::OP_PUBLISH:
            begin
                if (pub_go)
                begin
                    if (pb[0] != rd && pb[0] != NONE)
                    begin
                        old = rd;
                        rd = pb[0];
                        if (dst == rd)
                        begin
                            dst = NONE;
                            if (spr == NONE && free_ok(old, src, dst, rd, tv))
                                spr = old;
                            if (spr != NONE)
                            begin
                                dst = spr; spr = NONE;
                            end
                        end
                        else if (spr == NONE && free_ok(old, src, dst, rd, tv))
                        begin
                            spr = old;
                        end
                    end
                    ps[0] = ps[1]; pb[0] = pb[1];
                    ps[1] = ps[2]; pb[1] = pb[2];
                    pc = pc - 2'd1;
                end
            end
            tbom_pkg::OP_MARK:
            begin
                if (rd != NONE)
                begin
                    tf[rd] = item_reg.current_frame;
                    tv[rd] = 1'b1;
                end
                if (spr == rd)
                begin
                    spr = NONE;
                end
            end
            default: ;
        endcase
    end

    assign status.pub_more = pub_go;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == tbom_pkg::OP_LOAD)
        begin
            item_reg <= in_data;
        end
        for (int k = 0; k < 3; k++)
        begin
            tag_frame_reg[k] <= tf[k];
            pend_sess_reg[k] <= ps[k];
            pend_buf_reg[k]  <= pb[k];
        end
        wframe_reg <= wf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= 2'd0; dst_reg <= 2'd1; rd_reg <= 2'd0; spr_reg <= 2'd2;
            tag_valid_reg <= '0; pend_cnt_reg <= 2'd0;
            waited_reg <= 1'b0; err_reg <= 1'b0;
        end
        else
        begin
            src_reg <= src; dst_reg <= dst; rd_reg <= rd; spr_reg <= spr;
            tag_valid_reg <= tv; pend_cnt_reg <= pc;
            waited_reg <= w; err_reg <= e;
        end
    end

    assign out_data.src_index     = src_reg;
    assign out_data.dst_index     = dst_reg;
    assign out_data.read_index    = rd_reg;
    assign out_data.waited        = waited_reg;
    assign out_data.waited_frame  = waited_reg ? wframe_reg : 32'd0;
    assign out_data.no_free_error = err_reg;

    a_src_not_none: assert property (@(posedge clk) disable iff (!rst_n)
        src_reg != NONE)
        else $error("source lost");

    a_dst_spare_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (spr_reg != NONE) |-> (spr_reg != dst_reg && spr_reg != src_reg))
        else $error("spare overlaps role");

    a_error_no_dst: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (dst_reg == NONE))
        else $error("error with destination held");

endmodule

// ===== hdl/triple_buffer_ownership_manager.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_data  (tbom_pkg::in_item_t)
// out     | output    | out_valid/out_stall| out_data (tbom_pkg::out_item_t)
//
// commit and take: execute, then done, then the result is valid
// mark read: release first; publish: release, publish while ready, done
// one transaction at a time, set by the controller sequence
// asynchronous active-low reset restores the initial buffer roles
// a stalled result holds; the next transaction waits until it is taken
module triple_buffer_ownership_manager (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tbom_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tbom_pkg::out_item_t out_data
);

    tbom_pkg::dp_cmd_t    dp_cmd;
    tbom_pkg::dp_status_t status;

    tbom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_cmd    (in_data.cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .dp_cmd    (dp_cmd)
    );

    tbom_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .dp_cmd   (dp_cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// ===== bench/tbom_checker.sv =====
`timescale 1ns / 1ps

module tbom_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  tbom_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  tbom_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  pending_results
);

    // predicted buffer roles
    logic [1:0]  src_r, dst_r, rd_r, spare_r;
    logic [31:0] tag_frame [3];
    logic        tag_valid [3];
    logic [31:0] pend_sess [3];
    logic [1:0]  pend_buf [3];
    int          pend_cnt;
    logic        w_flag, e_flag;
    logic [31:0] w_frame;

    tbom_pkg::out_item_t role_queue [$];

    function automatic logic frame_done(logic [31:0] x, logic [31:0] fin);
        logic [31:0] d;
        d = fin - x;
        return d < 32'h8000_0000;
    endfunction

    function automatic logic claim_spare(int i);
        if (spare_r != tbom_pkg::NONE_IDX || i >= 3) return 0;
        if (i == src_r || i == dst_r || i == rd_r) return 0;
        if (tag_valid[i]) return 0;
        spare_r = i[1:0];
        return 1;
    endfunction

    task automatic free_finished(logic [31:0] fin);
        for (int i = 0; i < 3; i++)
        begin
            if (tag_valid[i] && frame_done(tag_frame[i], fin))
            begin
                tag_valid[i] = 0;
                void'(claim_spare(i));
            end
        end
    endtask

    task automatic force_spare(logic [31:0] fin);
        free_finished(fin);
        if (spare_r != tbom_pkg::NONE_IDX) return;
        for (int i = 0; i < 3; i++)
        begin
            if (i == src_r || i == dst_r || i == rd_r) continue;
            if (tag_valid[i])
            begin
                w_flag = 1;
                w_frame = tag_frame[i];
                tag_valid[i] = 0;
            end
            if (claim_spare(i)) return;
        end
        e_flag = 1;
    endtask

    task automatic remove_pending(int pos);
        for (int j = pos + 1; j < pend_cnt && j < 3; j++)
        begin
            pend_sess[j-1] = pend_sess[j];
            pend_buf[j-1] = pend_buf[j];
        end
        if (pend_cnt > 0) pend_cnt--;
    endtask

    task automatic make_read(logic [1:0] b);
        logic [1:0] old;
        old = rd_r;
        if (b == rd_r || b >= 3) return;
        rd_r = b;
        if (dst_r == rd_r)
        begin
            dst_r = tbom_pkg::NONE_IDX;
            void'(claim_spare(old));
            if (spare_r != tbom_pkg::NONE_IDX)
            begin
                dst_r = spare_r;
                spare_r = tbom_pkg::NONE_IDX;
            end
        end
        else
        begin
            void'(claim_spare(old));
        end
    endtask

    task automatic commit_write(logic [31:0] sess, logic [31:0] fin);
        logic [1:0] old_src;
        if (dst_r == tbom_pkg::NONE_IDX) return;
        for (int i = 0; i < pend_cnt && i < 3; i++)
        begin
            if (pend_buf[i] == dst_r)
            begin
                remove_pending(i);
                break;
            end
        end
        old_src = src_r;
        src_r = dst_r;
        if (old_src == rd_r)
        begin
            if (spare_r == tbom_pkg::NONE_IDX) force_spare(fin);
            dst_r = spare_r;
        end
        else
        begin
            dst_r = old_src;
        end
        spare_r = tbom_pkg::NONE_IDX;
        if (pend_cnt > 0 && pend_sess[pend_cnt-1] == sess)
        begin
            pend_buf[pend_cnt-1] = src_r;
            return;
        end
        if (pend_cnt >= 3) remove_pending(0);
        pend_sess[pend_cnt] = sess;
        pend_buf[pend_cnt] = src_r;
        pend_cnt++;
    endtask

    task automatic predict_roles(tbom_pkg::in_item_t t);
        tbom_pkg::out_item_t r;
        w_flag = 0;
        w_frame = '0;
        e_flag = 0;
        case (tbom_pkg::cmd_t'(t.cmd))
            tbom_pkg::CMD_COMMIT: commit_write(t.session_id, t.finished_frame);
            tbom_pkg::CMD_PUBLISH:
            begin
                free_finished(t.finished_frame);
                while (pend_cnt > 0 && frame_done(pend_sess[0], t.finished_session))
                begin
                    make_read(pend_buf[0]);
                    remove_pending(0);
                end
            end
            tbom_pkg::CMD_MARK:
            begin
                free_finished(t.finished_frame);
                if (rd_r < 3)
                begin
                    tag_frame[rd_r] = t.current_frame;
                    tag_valid[rd_r] = 1;
                end
                if (spare_r == rd_r) spare_r = tbom_pkg::NONE_IDX;
            end
            default:
            begin
                if (dst_r == tbom_pkg::NONE_IDX)
                begin
                    force_spare(t.finished_frame);
                    dst_r = spare_r;
                    spare_r = tbom_pkg::NONE_IDX;
                end
            end
        endcase
        r.src_index = src_r;
        r.dst_index = dst_r;
        r.read_index = rd_r;
        r.waited = w_flag;
        r.waited_frame = w_frame;
        r.no_free_error = e_flag;
        role_queue.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_results = role_queue.size();

    // observe both channels
    always @(posedge clk or negedge rst_n)
    begin
        tbom_pkg::out_item_t e;
        if (!rst_n)
        begin
            src_r = 0; dst_r = 1; rd_r = 0; spare_r = 2;
            for (int i = 0; i < 3; i++) tag_valid[i] = 0;
            pend_cnt = 0;
            role_queue.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (role_queue.size() == 0)
                begin
                    report_mismatch("unexpected transaction", 0, 0);
                end
                else
                begin
                    e = role_queue.pop_front();
                    if (out_data.src_index !== e.src_index)
                        report_mismatch("src_index", out_data.src_index, e.src_index);
                    if (out_data.dst_index !== e.dst_index)
                        report_mismatch("dst_index", out_data.dst_index, e.dst_index);
                    if (out_data.read_index !== e.read_index)
                        report_mismatch("read_index", out_data.read_index, e.read_index);
                    if (out_data.waited !== e.waited)
                        report_mismatch("waited", out_data.waited, e.waited);
                    if (out_data.waited_frame !== e.waited_frame)
                        report_mismatch("waited_frame", out_data.waited_frame, e.waited_frame);
                    if (out_data.no_free_error !== e.no_free_error)
                        report_mismatch("no_free_error", out_data.no_free_error,
                                        e.no_free_error);
                end
            end
            if (in_valid && !in_stall) predict_roles(in_data);
        end
    end

    initial fail_count = 0;
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT = 2000;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_stall;
    tbom_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 0;
    tbom_pkg::out_item_t out_data;
    int                  fail_count, pending_results;
    int                  idle_cycles = 0;
    bit                  calm = 0;
    int                  sent = 0;
    int                  frame_no = 1;
    int                  sess_no = 1;

    triple_buffer_ownership_manager dut (.*);

    tbom_checker u_checker (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .out_valid, .out_stall, .out_data, .fail_count, .pending_results
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                @(posedge clk);
                out_stall <= 0;
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    @(posedge clk);
                    out_stall <= $urandom_range(0, 2) == 0;
                end
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12))
                begin
                    @(posedge clk);
                    out_stall <= 1;
                end
            end
        end
    end

    task automatic send_item(tbom_pkg::cmd_t c, logic [31:0] s, logic [31:0] cur,
                             logic [31:0] ff, logic [31:0] fs);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= '{cmd: c, session_id: s, current_frame: cur,
                     finished_frame: ff, finished_session: fs};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // one well-formed step: sessions and frames move forward with small lag
    task automatic plausible_item();
        tbom_pkg::cmd_t c;
        c = tbom_pkg::cmd_t'($urandom_range(0, 3));
        if (c == tbom_pkg::CMD_COMMIT && $urandom_range(0, 1)) sess_no++;
        if (c == tbom_pkg::CMD_MARK) frame_no++;
        send_item(c, sess_no, frame_no, frame_no - $urandom_range(0, 3),
                  sess_no - $urandom_range(0, 2));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: each command, field extremes, wrap of finished compares
        send_item(tbom_pkg::CMD_TAKE, 0, 0, 0, 0);
        send_item(tbom_pkg::CMD_MARK, 0, 32'hFFFF_FFFF, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 5, 0, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 6, 0, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 7, 0, 0, 0);
        send_item(tbom_pkg::CMD_TAKE, 0, 0, 32'h7FFF_FFFF, 0);
        send_item(tbom_pkg::CMD_PUBLISH, 0, 0, 32'hFFFF_FFFF, 32'h8000_0005);
        send_item(tbom_pkg::CMD_PUBLISH, 0, 0, 32'h7FFF_FFFF, 32'h0000_0007);
        send_item(tbom_pkg::CMD_MARK, 0, 32'h8000_0000, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 9, 0, 0, 0);
        send_item(tbom_pkg::CMD_COMMIT, 10, 0, 0, 0);
        send_item(tbom_pkg::CMD_TAKE, 0, 0, 0, 0);
        send_item(tbom_pkg::CMD_PUBLISH, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(tbom_pkg::CMD_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(tbom_pkg::CMD_TAKE, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(tbom_pkg::CMD_COMMIT, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(tbom_pkg::CMD_PUBLISH, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // random: mostly plausible sequences, some raw noise
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i > RANDOM_ITEMS - 60) calm = 1;
            if ($urandom_range(0, 9) < 8) plausible_item();
            else send_item(tbom_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom,
                           $urandom, $urandom);
        end
        in_valid <= 0;
        while (pending_results != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d transactions across commit, publish, mark and take", sent);
        $display("with random stalls on both channels and wrap-around frame numbers");
        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
